// ===== hdl/can_id_dispatch_table_macros.svh =====
// Assertion macros shared by the CAN identifier dispatch table RTL.
// Each expects clk and an active-low rst_n in the scope of use.
`ifndef CAN_ID_DISPATCH_TABLE_MACROS_SVH
`define CAN_ID_DISPATCH_TABLE_MACROS_SVH

// condition holds at every clock edge out of reset
`define CIDT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CIDT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cidt_pkg.sv =====
// Shared types and constants of the CAN identifier dispatch table.
// No dependencies; used by every module of the block.
`default_nettype none

package cidt_pkg;

  localparam int STD_ENTRIES_DEF = 32;
  localparam int EXT_ENTRIES_DEF = 16;
  localparam int STD_ID_SPACE    = 2048;
  localparam int STD_ID_W        = $clog2(STD_ID_SPACE);

  localparam int IDENT_W = 29;
  localparam int BUS_W   = 2;
  localparam int TAG_W   = 8;
  localparam int SLOT_W  = 5;

  localparam logic CMD_REGISTER = 1'b0;
  localparam logic CMD_ROUTE    = 1'b1;

  localparam logic [1:0] KIND_REG  = 2'd0;
  localparam logic [1:0] KIND_HIT  = 2'd1;
  localparam logic [1:0] KIND_MISS = 2'd2;

  localparam logic [2:0] STAT_OK         = 3'd0;
  localparam logic [2:0] STAT_FULL       = 3'd1;
  localparam logic [2:0] STAT_TOO_LARGE  = 3'd2;
  localparam logic [2:0] STAT_TAKEN      = 3'd3;
  localparam logic [2:0] STAT_NO_HANDLER = 3'd4;

  typedef struct packed {
    logic               cmd;
    logic               id_is_ext;
    logic [IDENT_W-1:0] can_ident;
    logic [IDENT_W-1:0] accept_mask;
    logic [BUS_W-1:0]   bus_num;
    logic               has_handler;
    logic [TAG_W-1:0]   handler_tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot;
    logic              slot_is_ext;
    logic [TAG_W-1:0]  tag_out;
    logic              last;
  } out_item_t;

  // key travelling down the extended-entry chain
  typedef struct packed {
    logic               vld;
    logic [IDENT_W-1:0] ident;
    logic [BUS_W-1:0]   bus;
  } probe_t;

  typedef struct packed {
    logic [IDENT_W-1:0] ident;
    logic [IDENT_W-1:0] mask;
    logic [BUS_W-1:0]   bus;
    logic [TAG_W-1:0]   tag;
  } ext_entry_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_CHECK,
    S_INFO,
    S_SCAN,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/cidt_cell.sv =====
// One extended-table cell: holds an entry and a probe register, compares them.
// Depends on cidt_pkg.
`default_nettype none

module cidt_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            adv,
  input  wire cidt_pkg::probe_t                probe_in,
  output cidt_pkg::probe_t                     probe_out,
  input  wire logic [CNT_W-1:0]                count,
  input  wire logic                            wr_req,
  input  wire cidt_pkg::ext_entry_t            wr_data,
  output logic                                 hit,
  output logic [cidt_pkg::TAG_W-1:0]           tag
);

  cidt_pkg::probe_t     probe_r;
  cidt_pkg::ext_entry_t ent_r;
  logic                 live;

  // slot is populated once the fill count has passed it
  assign live = count > CNT_W'(IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r <= '0;
    end else if (adv) begin
      probe_r <= probe_in;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_req && (count == CNT_W'(IDX))) begin
      ent_r <= wr_data;
    end
  end

  assign hit = probe_r.vld && live && (ent_r.bus == probe_r.bus) &&
               ((probe_r.ident & ent_r.mask) == (ent_r.ident & ent_r.mask));
  assign tag       = ent_r.tag;
  assign probe_out = probe_r;

endmodule

`default_nettype wire

// ===== hdl/cidt_ext_chain.sv =====
// Row of extended-table cells; a probe walks one cell per advance.
// Depends on cidt_pkg, cidt_cell and the assertion macro header.
`default_nettype none
`include "can_id_dispatch_table_macros.svh"

module cidt_ext_chain #(
  parameter int EXT_ENTRIES = cidt_pkg::EXT_ENTRIES_DEF,
  localparam int ECW = $clog2(EXT_ENTRIES + 1),
  localparam int ESW = (EXT_ENTRIES > 1) ? $clog2(EXT_ENTRIES) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       adv,
  input  wire cidt_pkg::probe_t           probe_in,
  input  wire logic [ECW-1:0]             count,
  input  wire logic                       wr_req,
  input  wire cidt_pkg::ext_entry_t       wr_data,
  output logic                            hit_vld,
  output logic [ESW-1:0]                  hit_idx,
  output logic [cidt_pkg::TAG_W-1:0]      hit_tag,
  output logic                            busy,
  output logic                            tail_vld
);

  cidt_pkg::probe_t              link [EXT_ENTRIES+1];
  logic [EXT_ENTRIES-1:0]        hit_vec;
  logic [EXT_ENTRIES-1:0]        pvld_vec;
  logic [cidt_pkg::TAG_W-1:0]    tag_vec [EXT_ENTRIES];

  assign link[0] = probe_in;

  for (genvar g = 0; g < EXT_ENTRIES; g++) begin : g_cell
    cidt_cell #(
      .IDX   (g),
      .CNT_W (ECW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .probe_in  (link[g]),
      .probe_out (link[g+1]),
      .count     (count),
      .wr_req    (wr_req),
      .wr_data   (wr_data),
      .hit       (hit_vec[g]),
      .tag       (tag_vec[g])
    );
    assign pvld_vec[g] = link[g+1].vld;
  end

  // only one probe is in flight, so at most one cell reports
  always_comb begin
    hit_vld = 1'b0;
    hit_idx = '0;
    hit_tag = '0;
    for (int i = 0; i < EXT_ENTRIES; i++) begin
      if (hit_vec[i]) begin
        hit_vld = 1'b1;
        hit_idx = ESW'(i);
        hit_tag = tag_vec[i];
      end
    end
  end

  assign busy     = |pvld_vec;
  assign tail_vld = link[EXT_ENTRIES].vld;

  `CIDT_ASSERT_ALWAYS(a_one_probe, $onehot0(pvld_vec), "more than one probe in chain")
  `CIDT_ASSERT_ALWAYS(a_one_hit, $onehot0(hit_vec), "more than one cell hit at once")

endmodule

`default_nettype wire

// ===== hdl/cidt_std_tbl.sv =====
// Standard-identifier map (one entry per 11-bit id) and per-slot bus/tag store.
// Depends on cidt_pkg and the assertion macro header; sweeps the map after reset.
`default_nettype none
`include "can_id_dispatch_table_macros.svh"

module cidt_std_tbl #(
  parameter int STD_ENTRIES = cidt_pkg::STD_ENTRIES_DEF,
  localparam int SW = (STD_ENTRIES > 1) ? $clog2(STD_ENTRIES) : 1
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  output logic                                 clr_busy,
  input  wire logic [cidt_pkg::STD_ID_W-1:0]   map_addr,
  input  wire logic                            map_we,
  input  wire logic [SW-1:0]                   map_wslot,
  output logic                                 map_rvld,
  output logic [SW-1:0]                        map_rslot,
  input  wire logic                            info_we,
  input  wire logic [SW-1:0]                   info_waddr,
  input  wire logic [cidt_pkg::BUS_W-1:0]      info_wbus,
  input  wire logic [cidt_pkg::TAG_W-1:0]      info_wtag,
  input  wire logic [SW-1:0]                   info_raddr,
  output logic [cidt_pkg::BUS_W-1:0]           info_rbus,
  output logic [cidt_pkg::TAG_W-1:0]           info_rtag
);

  localparam int MAP_W  = SW + 1;
  localparam int INFO_W = cidt_pkg::BUS_W + cidt_pkg::TAG_W;

  logic [MAP_W-1:0]              map_mem [cidt_pkg::STD_ID_SPACE];
  logic [INFO_W-1:0]             info_mem [STD_ENTRIES];
  logic [MAP_W-1:0]              map_rdata_r;
  logic [INFO_W-1:0]             info_rdata_r;
  logic [cidt_pkg::STD_ID_W-1:0] clr_cnt_r;
  logic                          clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (&clr_cnt_r) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      map_mem[clr_cnt_r] <= '0;
    end else if (map_we) begin
      map_mem[map_addr] <= {1'b1, map_wslot};
    end
    map_rdata_r <= map_mem[map_addr];
  end

  always_ff @(posedge clk) begin
    if (info_we) begin
      info_mem[info_waddr] <= {info_wbus, info_wtag};
    end
    info_rdata_r <= info_mem[info_raddr];
  end

  assign clr_busy  = clr_busy_r;
  assign map_rvld  = map_rdata_r[MAP_W-1];
  assign map_rslot = map_rdata_r[SW-1:0];
  assign info_rbus = info_rdata_r[INFO_W-1:cidt_pkg::TAG_W];
  assign info_rtag = info_rdata_r[cidt_pkg::TAG_W-1:0];

  `CIDT_ASSERT_IMPL(a_no_write_in_clear, clr_busy_r, !map_we && !info_we,
                    "table write during clearing sweep")
  `CIDT_ASSERT_ALWAYS(a_map_info_paired, map_we == info_we,
                      "map and slot store written apart")

endmodule

`default_nettype wire

// ===== hdl/can_id_dispatch_table.sv =====
// CAN identifier dispatch table, top level: control sequencer and result register.
// Depends on cidt_pkg, cidt_std_tbl, cidt_ext_chain and the assertion macro header.
//
//   channel | direction | handshake            | beat
//   in_     | input     | in_valid / in_ready   | cidt_pkg::in_item_t
//   out_    | output    | out_valid / out_ready | cidt_pkg::out_item_t
//
// Standard items that need the map read it, and a route with a valid map entry then reads the slot store.
// An extended route walks the cell row, one cell per cycle unless a waiting hit holds the walk.
// After reset all STD_ID_SPACE (2048) map entries are swept clear; in_ready stays low meanwhile.
// A stalled out_ready holds the scan only when a second hit is waiting behind the first.
`default_nettype none
`include "can_id_dispatch_table_macros.svh"

module can_id_dispatch_table #(
  parameter int STD_ENTRIES = cidt_pkg::STD_ENTRIES_DEF,
  parameter int EXT_ENTRIES = cidt_pkg::EXT_ENTRIES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire cidt_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output cidt_pkg::out_item_t       out_data
);

  localparam int SW  = (STD_ENTRIES > 1) ? $clog2(STD_ENTRIES) : 1;
  localparam int SCW = $clog2(STD_ENTRIES + 1);
  localparam int ESW = (EXT_ENTRIES > 1) ? $clog2(EXT_ENTRIES) : 1;
  localparam int ECW = $clog2(EXT_ENTRIES + 1);

  cidt_pkg::state_t     state_r, state_nxt;
  cidt_pkg::in_item_t   key_r, key_nxt;
  cidt_pkg::out_item_t  resp_r, resp_nxt;
  cidt_pkg::out_item_t  out_data_r, out_data_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 pend_r, pend_nxt;
  logic [SCW-1:0]       std_count_r, std_count_nxt;
  logic [ECW-1:0]       ext_count_r, ext_count_nxt;

  logic                 in_acc;
  logic                 out_free;
  logic                 id_small;
  logic                 std_full;
  logic                 ext_full;
  logic                 need_lookup;

  logic                 clr_busy;
  logic                 map_we;
  logic                 map_rvld;
  logic [SW-1:0]        map_rslot;
  logic [cidt_pkg::BUS_W-1:0] info_rbus;
  logic [cidt_pkg::TAG_W-1:0] info_rtag;

  cidt_pkg::probe_t     probe_in;
  cidt_pkg::ext_entry_t ext_wdata;
  logic                 ext_wr_req;
  logic                 chain_adv;
  logic                 hit_vld;
  logic [ESW-1:0]       hit_idx;
  logic [cidt_pkg::TAG_W-1:0] hit_tag;
  logic                 chain_busy;
  logic                 tail_vld;

  function automatic cidt_pkg::out_item_t mk_resp(
    input logic [1:0]                  kind,
    input logic [2:0]                  status,
    input logic [cidt_pkg::SLOT_W-1:0] slot,
    input logic                        is_ext,
    input logic [cidt_pkg::TAG_W-1:0]  tag
  );
    cidt_pkg::out_item_t r;
    r.kind        = kind;
    r.status      = status;
    r.slot        = slot;
    r.slot_is_ext = is_ext;
    r.tag_out     = tag;
    r.last        = 1'b0;
    return r;
  endfunction

  assign in_ready = (state_r == cidt_pkg::S_IDLE) && !clr_busy;
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign id_small = in_data.can_ident < cidt_pkg::IDENT_W'(cidt_pkg::STD_ID_SPACE);
  assign std_full = std_count_r >= SCW'(STD_ENTRIES);
  assign ext_full = ext_count_r >= ECW'(EXT_ENTRIES);
  assign need_lookup = !in_data.id_is_ext && id_small &&
                       ((in_data.cmd == cidt_pkg::CMD_ROUTE) ||
                        (in_data.has_handler && !std_full));

  // hold the walk only when a new hit would overrun the waiting one
  assign chain_adv = (state_r != cidt_pkg::S_SCAN) || !hit_vld || !pend_r || out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cidt_pkg::S_CLEAR: begin
        if (!clr_busy) state_nxt = cidt_pkg::S_IDLE;
      end
      cidt_pkg::S_IDLE: begin
        if (in_acc) begin
          if ((in_data.cmd == cidt_pkg::CMD_ROUTE) && in_data.id_is_ext) begin
            state_nxt = cidt_pkg::S_SCAN;
          end else if (need_lookup) begin
            state_nxt = cidt_pkg::S_LOOKUP;
          end else begin
            state_nxt = cidt_pkg::S_EMIT;
          end
        end
      end
      cidt_pkg::S_LOOKUP: state_nxt = cidt_pkg::S_CHECK;
      cidt_pkg::S_CHECK: begin
        if ((key_r.cmd == cidt_pkg::CMD_ROUTE) && map_rvld) begin
          state_nxt = cidt_pkg::S_INFO;
        end else begin
          state_nxt = cidt_pkg::S_EMIT;
        end
      end
      cidt_pkg::S_INFO: state_nxt = cidt_pkg::S_EMIT;
      cidt_pkg::S_SCAN: begin
        if (chain_adv && tail_vld) state_nxt = cidt_pkg::S_EMIT;
      end
      cidt_pkg::S_EMIT: begin
        if (out_free) state_nxt = cidt_pkg::S_IDLE;
      end
      default: state_nxt = cidt_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    key_nxt       = in_acc ? in_data : key_r;
    resp_nxt      = resp_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    std_count_nxt = std_count_r;
    ext_count_nxt = ext_count_r;
    map_we        = 1'b0;
    ext_wr_req    = 1'b0;
    probe_in      = '0;

    ext_wdata.ident = in_data.can_ident;
    ext_wdata.mask  = in_data.accept_mask;
    ext_wdata.bus   = in_data.bus_num;
    ext_wdata.tag   = in_data.handler_tag;

    unique case (state_r)
      cidt_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_data.cmd == cidt_pkg::CMD_REGISTER) begin
            if (!in_data.has_handler) begin
              resp_nxt = mk_resp(cidt_pkg::KIND_REG, cidt_pkg::STAT_NO_HANDLER, '0, 1'b0, '0);
            end else if (in_data.id_is_ext) begin
              if (ext_full) begin
                resp_nxt = mk_resp(cidt_pkg::KIND_REG, cidt_pkg::STAT_FULL, '0, 1'b0, '0);
              end else begin
                ext_wr_req    = 1'b1;
                ext_count_nxt = ext_count_r + 1'b1;
                resp_nxt = mk_resp(cidt_pkg::KIND_REG, cidt_pkg::STAT_OK,
                                   cidt_pkg::SLOT_W'(ext_count_r), 1'b1, in_data.handler_tag);
              end
            end else if (std_full) begin
              resp_nxt = mk_resp(cidt_pkg::KIND_REG, cidt_pkg::STAT_FULL, '0, 1'b0, '0);
            end else if (!id_small) begin
              resp_nxt = mk_resp(cidt_pkg::KIND_REG, cidt_pkg::STAT_TOO_LARGE, '0, 1'b0, '0);
            end
          end else if (in_data.id_is_ext) begin
            probe_in.vld   = 1'b1;
            probe_in.ident = in_data.can_ident;
            probe_in.bus   = in_data.bus_num;
            pend_nxt       = 1'b0;
          end else if (!id_small) begin
            resp_nxt = mk_resp(cidt_pkg::KIND_MISS, cidt_pkg::STAT_OK, '0, 1'b0, '0);
          end
        end
      end
      cidt_pkg::S_CHECK: begin
        if (key_r.cmd == cidt_pkg::CMD_REGISTER) begin
          if (map_rvld) begin
            resp_nxt = mk_resp(cidt_pkg::KIND_REG, cidt_pkg::STAT_TAKEN, '0, 1'b0, '0);
          end else begin
            map_we        = 1'b1;
            std_count_nxt = std_count_r + 1'b1;
            resp_nxt = mk_resp(cidt_pkg::KIND_REG, cidt_pkg::STAT_OK,
                               cidt_pkg::SLOT_W'(std_count_r), 1'b0, key_r.handler_tag);
          end
        end else if (!map_rvld) begin
          resp_nxt = mk_resp(cidt_pkg::KIND_MISS, cidt_pkg::STAT_OK, '0, 1'b0, '0);
        end
      end
      cidt_pkg::S_INFO: begin
        if (info_rbus == key_r.bus_num) begin
          resp_nxt = mk_resp(cidt_pkg::KIND_HIT, cidt_pkg::STAT_OK,
                             cidt_pkg::SLOT_W'(map_rslot), 1'b0, info_rtag);
        end else begin
          resp_nxt = mk_resp(cidt_pkg::KIND_MISS, cidt_pkg::STAT_OK, '0, 1'b0, '0);
        end
      end
      cidt_pkg::S_SCAN: begin
        if (chain_adv && hit_vld) begin
          // a newer hit exists, so the waiting one is not the last
          if (pend_r) begin
            out_valid_nxt     = 1'b1;
            out_data_nxt      = resp_r;
            out_data_nxt.last = 1'b0;
          end
          resp_nxt = mk_resp(cidt_pkg::KIND_HIT, cidt_pkg::STAT_OK,
                             cidt_pkg::SLOT_W'(hit_idx), 1'b1, hit_tag);
          pend_nxt = 1'b1;
        end else if (chain_adv && tail_vld && !pend_r) begin
          resp_nxt = mk_resp(cidt_pkg::KIND_MISS, cidt_pkg::STAT_OK, '0, 1'b0, '0);
        end
      end
      cidt_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_data_nxt      = resp_r;
          out_data_nxt.last = 1'b1;
          pend_nxt          = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cidt_pkg::S_CLEAR;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      std_count_r <= '0;
      ext_count_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      std_count_r <= std_count_nxt;
      ext_count_r <= ext_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    resp_r     <= resp_nxt;
    out_data_r <= out_data_nxt;
  end

  cidt_std_tbl #(
    .STD_ENTRIES (STD_ENTRIES)
  ) u_std_tbl (
    .clk        (clk),
    .rst_n      (rst_n),
    .clr_busy   (clr_busy),
    .map_addr   (key_r.can_ident[cidt_pkg::STD_ID_W-1:0]),
    .map_we     (map_we),
    .map_wslot  (SW'(std_count_r)),
    .map_rvld   (map_rvld),
    .map_rslot  (map_rslot),
    .info_we    (map_we),
    .info_waddr (SW'(std_count_r)),
    .info_wbus  (key_r.bus_num),
    .info_wtag  (key_r.handler_tag),
    .info_raddr (map_rslot),
    .info_rbus  (info_rbus),
    .info_rtag  (info_rtag)
  );

  cidt_ext_chain #(
    .EXT_ENTRIES (EXT_ENTRIES)
  ) u_ext_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (chain_adv),
    .probe_in (probe_in),
    .count    (ext_count_r),
    .wr_req   (ext_wr_req),
    .wr_data  (ext_wdata),
    .hit_vld  (hit_vld),
    .hit_idx  (hit_idx),
    .hit_tag  (hit_tag),
    .busy     (chain_busy),
    .tail_vld (tail_vld)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CIDT_ASSERT_ALWAYS(a_counts_bounded,
                      (std_count_r <= SCW'(STD_ENTRIES)) && (ext_count_r <= ECW'(EXT_ENTRIES)),
                      "fill count beyond table size")
  `CIDT_ASSERT_IMPL(a_chain_empty_off_scan, (state_r != cidt_pkg::S_SCAN), !chain_busy,
                    "probe in cell row outside a scan")

endmodule

`default_nettype wire

// ===== bench/can_id_dispatch_table_checker.sv =====
`timescale 1ns / 100ps
// Channel monitor for the CAN identifier dispatch table: mirrors both tables and
// checks every result beat against its own routing prediction.
// Depends on cidt_pkg only.

module can_id_dispatch_table_checker
  import cidt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        beats_checked,
  output int        backlog
);

  bit                std_known   [STD_ID_SPACE];
  logic [SLOT_W-1:0] std_slot_of [STD_ID_SPACE];
  logic [BUS_W-1:0]  std_bus_of  [STD_ENTRIES_DEF];
  logic [TAG_W-1:0]  std_tag_of  [STD_ENTRIES_DEF];
  ext_entry_t        ext_rows    [EXT_ENTRIES_DEF];
  int                std_used_slots = 0;
  int                ext_used_slots = 0;
  out_item_t         table_results [$];
  out_item_t         want;

  int mismatches = 0;
  int checked    = 0;
  int queued     = 0;

  assign fail_count    = mismatches;
  assign beats_checked = checked;
  assign backlog       = queued;

  function automatic out_item_t result_beat(logic [1:0] kind, logic [2:0] status,
                                            logic [SLOT_W-1:0] slot, logic is_ext,
                                            logic [TAG_W-1:0] tag, logic last);
    return out_item_t'{kind, status, slot, is_ext, tag, last};
  endfunction

  function automatic bit ext_hit(ext_entry_t row, in_item_t b);
    return row.bus == b.bus_num && (b.can_ident & row.mask) == (row.ident & row.mask);
  endfunction

  task automatic apply_table_op(input in_item_t b);
    logic [STD_ID_W-1:0] idx;
    int                  last_match;
    int                  s;
    idx = b.can_ident[STD_ID_W-1:0];
    if (b.cmd == CMD_REGISTER) begin
      // refusal order: handler, then fullness, then range, then duplicate
      if (!b.has_handler) begin
        table_results.push_back(result_beat(KIND_REG, STAT_NO_HANDLER, '0, 1'b0, '0, 1'b1));
      end else if (!b.id_is_ext) begin
        if (std_used_slots >= STD_ENTRIES_DEF) begin
          table_results.push_back(result_beat(KIND_REG, STAT_FULL, '0, 1'b0, '0, 1'b1));
        end else if (b.can_ident >= STD_ID_SPACE) begin
          table_results.push_back(result_beat(KIND_REG, STAT_TOO_LARGE, '0, 1'b0, '0, 1'b1));
        end else if (std_known[idx]) begin
          table_results.push_back(result_beat(KIND_REG, STAT_TAKEN, '0, 1'b0, '0, 1'b1));
        end else begin
          s = std_used_slots;
          std_known[idx]   = 1'b1;
          std_slot_of[idx] = SLOT_W'(s);
          std_bus_of[s]    = b.bus_num;
          std_tag_of[s]    = b.handler_tag;
          std_used_slots++;
          table_results.push_back(result_beat(KIND_REG, STAT_OK, SLOT_W'(s), 1'b0,
                                              b.handler_tag, 1'b1));
        end
      end else if (ext_used_slots >= EXT_ENTRIES_DEF) begin
        table_results.push_back(result_beat(KIND_REG, STAT_FULL, '0, 1'b0, '0, 1'b1));
      end else begin
        s = ext_used_slots;
        ext_rows[s] = ext_entry_t'{b.can_ident, b.accept_mask, b.bus_num, b.handler_tag};
        ext_used_slots++;
        table_results.push_back(result_beat(KIND_REG, STAT_OK, SLOT_W'(s), 1'b1,
                                            b.handler_tag, 1'b1));
      end
    end else if (!b.id_is_ext) begin
      if (b.can_ident < STD_ID_SPACE && std_known[idx] &&
          std_bus_of[std_slot_of[idx]] == b.bus_num) begin
        table_results.push_back(result_beat(KIND_HIT, STAT_OK, std_slot_of[idx], 1'b0,
                                            std_tag_of[std_slot_of[idx]], 1'b1));
      end else begin
        table_results.push_back(result_beat(KIND_MISS, STAT_OK, '0, 1'b0, '0, 1'b1));
      end
    end else begin
      last_match = -1;
      for (s = 0; s < ext_used_slots; s++)
        if (ext_hit(ext_rows[s], b)) last_match = s;
      if (last_match < 0) begin
        table_results.push_back(result_beat(KIND_MISS, STAT_OK, '0, 1'b0, '0, 1'b1));
      end else begin
        for (s = 0; s <= last_match; s++)
          if (ext_hit(ext_rows[s], b))
            table_results.push_back(result_beat(KIND_HIT, STAT_OK, SLOT_W'(s), 1'b1,
                                                ext_rows[s].tag, s == last_match));
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (std_known[i]) std_known[i] = 1'b0;
      std_used_slots = 0;
      ext_used_slots = 0;
      table_results.delete();
    end else begin
      // a new beat is queued before the result side pops, so order holds on a shared edge
      if (in_valid && in_ready) apply_table_op(in_data);
      if (out_valid && out_ready) begin
        checked++;
        if (table_results.size() == 0) begin
          $error("result beat with nothing pending: kind %0d slot %0d tag %0d",
                 out_data.kind, out_data.slot, out_data.tag_out);
          mismatches++;
        end else begin
          want = table_results.pop_front();
          compare_field("kind", want.kind, out_data.kind);
          compare_field("status", want.status, out_data.status);
          compare_field("slot", want.slot, out_data.slot);
          compare_field("slot_is_ext", want.slot_is_ext, out_data.slot_is_ext);
          compare_field("tag_out", want.tag_out, out_data.tag_out);
          compare_field("last", want.last, out_data.last);
        end
      end
    end
    queued = table_results.size();
  end

endmodule

// ===== bench/can_id_dispatch_table_tb.sv =====
`timescale 1ns / 100ps
// Top of the CAN identifier dispatch table bench: clock, reset, beat stimulus and verdict.
// Depends on cidt_pkg, can_id_dispatch_table and can_id_dispatch_table_checker.

module can_id_dispatch_table_tb;
  import cidt_pkg::*;

  localparam int RESET_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 40;
  localparam int MIXED_BEATS  = 20;
  localparam logic [IDENT_W-1:0] ID_ALL = {IDENT_W{1'b1}};

  typedef enum int {
    RDY_ALWAYS,
    RDY_THREE_IN_FOUR,
    RDY_COIN,
    RDY_ONE_IN_FIVE
  } ready_mode_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;

  int          fail_total;
  int          checked_total;
  int          pending_beats;
  int          cycle_count = 0;
  int          burst_left  = 0;
  int          reg_beats   = 0;
  int          route_beats = 0;
  ready_mode_t ready_mode  = RDY_ALWAYS;
  int          mode_left   = 0;
  int          ready_tick  = 0;

  // stimulus-side bookkeeping of which registrations land, used to aim routes
  bit          std_taken [STD_ID_SPACE];
  in_item_t    std_entries [$];
  in_item_t    ext_entries [$];

  always #6 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  can_id_dispatch_table uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  can_id_dispatch_table_checker table_watch (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_total),
    .beats_checked (checked_total),
    .backlog       (pending_beats)
  );

  // result side: stall pattern switches mode at random intervals
  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(16, 96);
    end
    mode_left--;
    ready_tick++;
    case (ready_mode)
      RDY_ALWAYS:        out_ready <= 1'b1;
      RDY_THREE_IN_FOUR: out_ready <= (ready_tick % 4 != 0);
      RDY_COIN:          out_ready <= 1'($urandom_range(0, 1));
      default:           out_ready <= (ready_tick % 5 == 0);
    endcase
  end

  function automatic in_item_t make_beat(logic cmd, logic is_ext, logic [IDENT_W-1:0] ident,
                                         logic [IDENT_W-1:0] mask, logic [BUS_W-1:0] bus,
                                         logic handler, logic [TAG_W-1:0] tag);
    return in_item_t'{cmd, is_ext, ident, mask, bus, handler, tag};
  endfunction

  function automatic in_item_t random_beat(int reg_pct);
    in_item_t b;
    in_item_t pick;
    int       r;
    b.cmd         = ($urandom_range(0, 99) < reg_pct) ? CMD_REGISTER : CMD_ROUTE;
    b.id_is_ext   = ($urandom_range(0, 2) == 0);
    b.can_ident   = IDENT_W'($urandom());
    b.accept_mask = IDENT_W'($urandom());
    b.bus_num     = BUS_W'($urandom());
    b.has_handler = ($urandom_range(0, 7) != 0);
    b.handler_tag = TAG_W'($urandom());
    r = $urandom_range(0, 9);
    if (!b.id_is_ext) begin
      // mostly in range; the rest a full-width identifier, nearly always too large
      if (r < 7) b.can_ident = IDENT_W'($urandom_range(0, STD_ID_SPACE - 1));
      if (r >= 2 && r < 7 && std_entries.size() > 0) begin
        pick = std_entries[$urandom_range(0, std_entries.size() - 1)];
        b.can_ident = pick.can_ident;
        if (r != 6) b.bus_num = pick.bus_num;
      end
    end else if (b.cmd == CMD_REGISTER) begin
      if (r < 4) b.bus_num = 2'd2;
      case (r % 4)
        0: b.accept_mask = '0;
        1: b.accept_mask = ID_ALL;
        2: b.accept_mask = b.accept_mask & (ID_ALL << $urandom_range(0, IDENT_W - 1));
        default: ;
      endcase
    end else if (r < 7 && ext_entries.size() > 0) begin
      // keep the masked bits of a stored entry, scramble the don't-care bits
      pick = ext_entries[$urandom_range(0, ext_entries.size() - 1)];
      b.can_ident = pick.can_ident ^ (b.can_ident & ~pick.accept_mask);
      if (r < 6) b.bus_num = pick.bus_num;
    end
    return b;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_beat(input in_item_t b);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 6);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    if (b.cmd == CMD_ROUTE) begin
      route_beats++;
    end else begin
      reg_beats++;
      if (b.has_handler && !b.id_is_ext && b.can_ident < STD_ID_SPACE &&
          !std_taken[b.can_ident[STD_ID_W-1:0]] && std_entries.size() < STD_ENTRIES_DEF) begin
        std_taken[b.can_ident[STD_ID_W-1:0]] = 1'b1;
        std_entries.push_back(b);
      end else if (b.has_handler && b.id_is_ext && ext_entries.size() < EXT_ENTRIES_DEF) begin
        ext_entries.push_back(b);
      end
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending_beats != 0);
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    in_item_t b;
    int       idx;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // standard table: refusals in priority order, then the identifier extremes
    send_beat(make_beat(CMD_REGISTER, 1'b0, 29'd4000, '0, 2'd0, 1'b0, 8'h11));
    send_beat(make_beat(CMD_REGISTER, 1'b0, 29'd2048, '0, 2'd0, 1'b1, 8'h22));
    send_beat(make_beat(CMD_REGISTER, 1'b0, ID_ALL, ID_ALL, 2'd1, 1'b1, 8'h33));
    send_beat(make_beat(CMD_REGISTER, 1'b0, 29'd0, '0, 2'd0, 1'b1, 8'h00));
    send_beat(make_beat(CMD_REGISTER, 1'b0, 29'd2047, ID_ALL, 2'd3, 1'b1, 8'hFF));
    send_beat(make_beat(CMD_REGISTER, 1'b0, 29'd0, '0, 2'd1, 1'b1, 8'h77));
    send_beat(make_beat(CMD_ROUTE, 1'b0, 29'd0, ID_ALL, 2'd0, 1'b0, 8'hFF));
    send_beat(make_beat(CMD_ROUTE, 1'b0, 29'd0, '0, 2'd1, 1'b1, 8'h00));
    send_beat(make_beat(CMD_ROUTE, 1'b0, 29'd2047, '0, 2'd3, 1'b0, 8'h00));
    // aliases onto identifier 0 in the low bits but is out of range
    send_beat(make_beat(CMD_ROUTE, 1'b0, 29'd2048, '0, 2'd0, 1'b1, 8'h00));
    send_beat(make_beat(CMD_ROUTE, 1'b0, 29'd100, '0, 2'd0, 1'b0, 8'h00));

    // extended table: wildcard, exact and partial masks, multi-hit routes
    send_beat(make_beat(CMD_REGISTER, 1'b1, ID_ALL, ID_ALL, 2'd2, 1'b0, 8'h44));
    send_beat(make_beat(CMD_REGISTER, 1'b1, ID_ALL, ID_ALL, 2'd2, 1'b1, 8'hA5));
    send_beat(make_beat(CMD_REGISTER, 1'b1, 29'd0, '0, 2'd2, 1'b1, 8'h5A));
    send_beat(make_beat(CMD_REGISTER, 1'b1, 29'h12345678, 29'h1FFFF000, 2'd2, 1'b1, 8'h3C));
    send_beat(make_beat(CMD_REGISTER, 1'b1, 29'h00ABCDEF, ID_ALL, 2'd3, 1'b1, 8'hC3));
    send_beat(make_beat(CMD_ROUTE, 1'b1, ID_ALL, '0, 2'd2, 1'b0, 8'h00));
    send_beat(make_beat(CMD_ROUTE, 1'b1, 29'h12345ABC, '0, 2'd2, 1'b0, 8'h00));
    send_beat(make_beat(CMD_ROUTE, 1'b1, 29'h00ABCDEF, '0, 2'd3, 1'b0, 8'h00));
    send_beat(make_beat(CMD_ROUTE, 1'b1, 29'd0, '0, 2'd1, 1'b0, 8'h00));
    // extended frame with a standard entry's identifier: the standard map is not consulted
    send_beat(make_beat(CMD_ROUTE, 1'b1, 29'd0, '0, 2'd0, 1'b0, 8'h00));

    repeat (MIXED_BEATS) send_beat(random_beat(50));
    hold_until_drained();

    // fill both tables with fresh entries, routing in between
    while (std_entries.size() < STD_ENTRIES_DEF || ext_entries.size() < EXT_ENTRIES_DEF) begin
      b = random_beat(100);
      b.has_handler = 1'b1;
      b.id_is_ext = (std_entries.size() >= STD_ENTRIES_DEF) ||
                    (ext_entries.size() < EXT_ENTRIES_DEF && $urandom_range(0, 2) == 0);
      if (!b.id_is_ext) begin
        do idx = $urandom_range(0, STD_ID_SPACE - 1); while (std_taken[idx]);
        b.can_ident = IDENT_W'(idx);
      end
      send_beat(b);
      if ($urandom_range(0, 2) == 0) send_beat(random_beat(0));
    end
    // full check comes before range and duplicate checks
    send_beat(make_beat(CMD_REGISTER, 1'b0, 29'd2047, '0, 2'd0, 1'b1, 8'h5A));
    send_beat(make_beat(CMD_REGISTER, 1'b1, 29'd0, '0, 2'd0, 1'b1, 8'hA5));

    repeat (MIXED_BEATS) send_beat(random_beat(25));
    hold_until_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d register and %0d route beats; tables reached %0d standard and %0d ext",
             reg_beats, route_beats, std_entries.size(), ext_entries.size());
    $display("Compared %0d result beats, %0d field mismatches", checked_total, fail_total);
    if (fail_total == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
